// ===== rtl/frd_pkg.sv =====
`default_nettype none
package frd_pkg;
    typedef struct packed {
        logic [15:0] numerator;
        logic [5:0]  denominator;
    } t_in;
    typedef struct packed {
        logic [5:0] character;
        logic       last_char;
    } t_out;
    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_POINT = 6'd46;
    localparam logic [5:0] CH_OPEN  = 6'd40;
    localparam logic [5:0] CH_CLOSE = 6'd41;
    localparam int         MAX_OUT  = 64;
endpackage
`default_nettype wire

// ===== rtl/frd_front.sv =====
`default_nettype none
module frd_front
    import frd_pkg::*;
#(
    parameter int MAX_DENOMINATOR = 48,
    parameter int NUMERATOR_BITS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_in       o_data
);
    // two-entry queue of cleaned-up fractions
    t_in        r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    t_in        w_clean;
    logic [5:0] w_den;
    logic       w_push, w_pop;

    always_comb begin
        w_den = i_data.denominator;
        if (w_den == 6'd0) w_den = 6'd1;
        if (32'(w_den) > MAX_DENOMINATOR) w_den = 6'(MAX_DENOMINATOR);
        w_clean.numerator   = i_data.numerator &
                              16'((17'd1 << NUMERATOR_BITS) - 17'd1);
        w_clean.denominator = w_den;
    end

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && !i_stall;
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_clean;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue overflow");
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.denominator != 6'd0))
        else $error("zero denominator queued");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_rd == r_wr))
        else $error("pointer mismatch");
endmodule
`default_nettype wire

// ===== rtl/frd_back.sv =====
`default_nettype none
module frd_back
    import frd_pkg::*;
#(
    parameter int MAX_DENOMINATOR = 48
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);
    localparam int RW = $clog2(MAX_DENOMINATOR);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_IDIV   = 9'b000000010,
        S_ISPLIT = 9'b000000100,
        S_IEMIT  = 9'b000001000,
        S_POINT  = 9'b000010000,
        S_FDIV   = 9'b000100000,
        S_FSTEP  = 9'b001000000,
        S_FSEEN  = 9'b010000000,
        S_FEMIT  = 9'b100000000
    } t_state;

    t_state      r_state;
    logic [15:0] r_num;      // restoring division: dividend / quotient
    logic [5:0]  r_den;
    logic [5:0]  r_rem;
    logic [4:0]  r_bit;
    logic [3:0]  r_dig [5];  // integer digits, little end first
    logic [2:0]  r_nint, r_iidx;
    logic [15:0] r_iq;
    logic [MAX_DENOMINATOR-1:0] r_seen;
    logic [5:0]  r_first [MAX_DENOMINATOR];
    logic [5:0]  r_first_q;
    logic [3:0]  r_buf [MAX_OUT];
    logic [3:0]  r_bq;
    logic [6:0]  r_ndig, r_fidx;
    logic [5:0]  r_start;
    logic        r_rep;
    logic        r_open;
    logic [6:0]  r_cnt;      // characters sent
    logic [5:0]  r_char;
    logic        r_last;
    logic        r_ov;
    logic [3:0]  r_rd;

    // output register
    assign o_valid = r_ov;
    assign o_data  = '{character: r_char, last_char: r_last};
    assign o_stall = (r_state != S_IDLE);

    // one restoring step on 16-bit dividend, borrow in the top bit
    logic [6:0] w_sh;
    logic [7:0] w_trial;
    assign w_sh    = {r_rem, r_num[15]};
    assign w_trial = {1'b0, w_sh} - {2'b00, r_den};

    // divide by ten through a reciprocal, exact for any 16-bit value
    logic [31:0] w_prod;
    logic [15:0] w_q10, w_d10;
    assign w_prod = 32'(r_iq) * 32'd52429;
    assign w_q10  = {3'd0, w_prod[31:19]};
    assign w_d10  = r_iq - 16'(w_q10 * 16'd10);

    // fraction digit: 10*r / den by repeated subtraction
    logic [9:0] w_r10;
    logic [RW-1:0] w_ridx;
    assign w_r10  = {4'd0, r_rem} * 10'd10;
    assign w_ridx = RW'(r_rem);

    logic       w_free, w_emit, w_fdone, w_open_now, w_dig_go, w_cap;
    logic       w_fless, w_first_we, w_buf_we;
    logic [5:0] w_raddr;
    assign w_free     = !r_ov || !i_stall;
    assign w_emit     = w_free && (r_state == S_IEMIT || r_state == S_POINT ||
                                   r_state == S_FEMIT);
    assign w_fdone    = (r_rem == 6'd0) || (r_ndig == 7'(MAX_OUT));
    assign w_open_now = r_rep && !r_open && (r_fidx == {1'b0, r_start});
    assign w_dig_go   = (r_state == S_FEMIT) && w_free && !w_open_now &&
                        (r_fidx != r_ndig);
    // read one digit ahead so the buffer data is ready when it is sent
    assign w_raddr    = w_dig_go ? r_fidx[5:0] + 6'd1 : r_fidx[5:0];
    assign w_cap      = (r_cnt == 7'(MAX_OUT - 1));
    assign w_fless    = (r_num[9:0] < {4'd0, r_den});
    assign w_first_we = (r_state == S_FDIV) && !w_fdone && !r_seen[w_ridx];
    assign w_buf_we   = (r_state == S_FSTEP) && w_fless;

    always_ff @(posedge i_clk) begin
        if (w_first_we) r_first[w_ridx] <= r_ndig[5:0];
        r_first_q <= r_first[w_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (w_buf_we) r_buf[r_ndig[5:0]] <= r_rd;
        r_bq <= r_buf[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_seen  <= '0;
            r_cnt   <= '0;
        end else begin
            if (w_emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_num   <= i_data.numerator;
                    r_den   <= i_data.denominator;
                    r_rem   <= '0;
                    r_bit   <= 5'd16;
                    r_cnt   <= '0;
                    r_seen  <= '0;
                    r_ndig  <= '0;
                    r_fidx  <= '0;
                    r_rep   <= 1'b0;
                    r_open  <= 1'b0;
                    r_state <= S_IDIV;
                end
                S_IDIV: begin
                    if (r_bit != 5'd0) begin
                        if (!w_trial[7]) r_rem <= w_trial[5:0];
                        else r_rem <= w_sh[5:0];
                        r_num <= {r_num[14:0], !w_trial[7]};
                        r_bit <= r_bit - 5'd1;
                    end else begin
                        r_iq    <= r_num;
                        r_nint  <= '0;
                        r_state <= S_ISPLIT;
                    end
                end
                S_ISPLIT: begin
                    // split quotient into digits: one per cycle
                    r_dig[r_nint] <= w_d10[3:0];
                    r_iq <= w_q10;
                    if (w_q10 == 16'd0) begin
                        r_iidx  <= r_nint;
                        r_state <= S_IEMIT;
                    end else r_nint <= r_nint + 3'd1;
                end
                S_IEMIT: if (w_free) begin
                    r_char <= CH_ZERO + 6'(r_dig[r_iidx]);
                    r_last <= (r_iidx == 3'd0) && (r_rem == 6'd0);
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_iidx != 3'd0) r_iidx <= r_iidx - 3'd1;
                    else if (r_rem == 6'd0) r_state <= S_IDLE;
                    else r_state <= S_POINT;
                end
                S_POINT: if (w_free) begin
                    r_char  <= CH_POINT;
                    r_last  <= 1'b0;
                    r_cnt   <= r_cnt + 7'd1;
                    r_state <= S_FDIV;
                end
                S_FDIV: begin
                    if (w_fdone) begin
                        r_state <= S_FEMIT;
                    end else if (r_seen[w_ridx]) begin
                        // first index comes back from the table next cycle
                        r_rep   <= 1'b1;
                        r_state <= S_FSEEN;
                    end else begin
                        r_seen[w_ridx] <= 1'b1;
                        r_num   <= {6'd0, w_r10};
                        r_rd    <= 4'd0;
                        r_state <= S_FSTEP;
                    end
                end
                S_FSTEP: begin
                    // subtract den until below it
                    if (!w_fless) begin
                        r_num <= r_num - {10'd0, r_den};
                        r_rd  <= r_rd + 4'd1;
                    end else begin
                        r_ndig  <= r_ndig + 7'd1;
                        r_rem   <= r_num[5:0];
                        r_state <= S_FDIV;
                    end
                end
                S_FSEEN: begin
                    r_start <= r_first_q;
                    r_state <= S_FEMIT;
                end
                S_FEMIT: if (w_free) begin
                    r_cnt <= r_cnt + 7'd1;
                    if (w_open_now) begin
                        r_char <= CH_OPEN;
                        r_open <= 1'b1;
                        r_last <= w_cap;
                        if (w_cap) r_state <= S_IDLE;
                    end else if (r_fidx != r_ndig) begin
                        r_char <= CH_ZERO + 6'(r_bq);
                        r_fidx <= r_fidx + 7'd1;
                        r_last <= w_cap || (!r_rep && r_fidx + 7'd1 == r_ndig);
                        if (w_cap || (!r_rep && r_fidx + 7'd1 == r_ndig))
                            r_state <= S_IDLE;
                    end else begin
                        r_char  <= CH_CLOSE;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'(MAX_OUT))
        else $error("too many characters");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/fraction_to_repeating_decimal_unit.sv =====
`default_nettype none
// the input passes the front queue, then a 16-step integer division, then the
// quotient is split into integer digits before the first character is sent
// fraction digits: each by multiplying by ten and serial subtraction, all
// computed before the first fraction character, then one character a cycle
// unless the output stalls; the back end takes a new fraction only when idle
// reset: synchronous active low, clears the queue, state and seen flags
module fraction_to_repeating_decimal_unit
    import frd_pkg::*;
#(
    parameter int MAX_DENOMINATOR = 48,
    parameter int NUMERATOR_BITS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);
    // front: cleans up the fraction and holds it in a short queue
    logic q_valid, q_stall;
    t_in  q_data;

    frd_front #(
        .MAX_DENOMINATOR(MAX_DENOMINATOR),
        .NUMERATOR_BITS(NUMERATOR_BITS)
    ) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid(q_valid), .i_stall(q_stall), .o_data(q_data)
    );

    // back: long division and character transfer
    frd_back #(.MAX_DENOMINATOR(MAX_DENOMINATOR)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_stall(q_stall), .i_data(q_data),
        .o_valid, .i_stall, .o_data
    );
endmodule
`default_nettype wire
